// ===== rtl/mi3_pkg.sv =====
// Shared constants and types for the 3x3 matrix inverse core.
// Cofactor index table, port widths and result flag positions.
// No dependencies.
package mi3_pkg;

   localparam int WORD_W      = 32;
   localparam int IN_COUNT    = 9;
   localparam int OUT_COUNT   = 10;
   localparam int IN_TDATA_W  = WORD_W * IN_COUNT;
   localparam int OUT_TDATA_W = WORD_W * OUT_COUNT;
   localparam int USER_W      = 2;

   localparam int USER_SINGULAR  = 0;
   localparam int USER_SATURATED = 1;

   typedef logic [3:0] idx_type;

   // adj[k] = m[a]*m[b] - m[c]*m[d], elements row-major
   localparam idx_type COF_IDX [0:8][0:3] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd1, 4'd6, 4'd0, 4'd7},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   // cofactors that pair with row 0 in the determinant
   localparam idx_type DET_COF [0:2] = '{4'd0, 4'd3, 4'd6};

endpackage

// ===== rtl/matrix_inverse_3x3_core.sv =====
// 3x3 matrix inverse by adjugate with exact determinant and pipelined divider.
// Throughput: one matrix per cycle while the output skid is empty; depth set by
// the restoring divider, one quotient bit per stage for nine lanes sharing the
// divisor.
// Reset clears all valid bits and the output skid; payload registers are not reset.
// Depends on mi3_pkg.
module matrix_inverse_3x3_core #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // in_r0c0, in_r0c1, in_r0c2, in_r1c0 .. in_r2c2, 32 bits each
   input  logic [mi3_pkg::IN_TDATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_r0c0 .. out_r2c2, det_value, 32 bits each
   output logic [mi3_pkg::OUT_TDATA_W-1:0]  rsp_tdata,
   // singular, saturated
   output logic [mi3_pkg::USER_W-1:0]       rsp_tuser
);

   localparam int WW = mi3_pkg::WORD_W;
   localparam int E  = ELEM_WIDTH;
   localparam int F2 = 2 * FRAC_BITS;
   localparam int PW = 2 * E;
   localparam int CW = 2 * E + 1;
   localparam int LW = 2 * E + 1;
   localparam int DW = 3 * E + 3;
   localparam int NW = CW + F2;
   localparam int RW = (NW > DW + E) ? NW : DW + E;

   logic pipe_en;
   logic [6:0] v_ff;
   logic [E:0] dv_ff;

   logic signed [E-1:0]  m_ff   [0:8];
   logic signed [PW-1:0] p_ff   [0:17];
   logic signed [E-1:0]  r1_ff  [0:2];
   logic signed [E-1:0]  r2_ff  [0:2];
   logic signed [CW-1:0] c2_ff  [0:8];
   logic signed [CW-1:0] c3_ff  [0:8];
   logic signed [CW-1:0] c4_ff  [0:8];
   logic signed [CW-1:0] c5_ff  [0:8];
   logic signed [LW-1:0] lo_ff  [0:2];
   logic signed [LW-1:0] hi_ff  [0:2];
   logic signed [DW-1:0] pr_ff  [0:2];
   logic signed [DW-1:0] det_ff;

   logic [NW-1:0]       num_ff  [0:8];
   logic [DW-1:0]       den6_ff;
   logic                neg6_ff [0:8];
   logic                sing6_ff;
   logic signed [E-1:0] dval6_ff;
   logic                dclip6_ff;

   logic [NW-1:0]       num_in  [0:8];
   logic [DW-1:0]       den6_in;
   logic                neg6_in [0:8];
   logic signed [E-1:0] dval6_in;
   logic                dclip6_in;

   logic [RW-1:0]       rem_ff  [0:E][0:8];
   logic [E-1:0]        q_ff    [0:E][0:8];
   logic                ovf_ff  [0:E][0:8];
   logic                neg_ff  [0:E][0:8];
   logic [DW-1:0]       den_ff  [0:E];
   logic                sing_ff [0:E];
   logic signed [E-1:0] dval_ff [0:E];
   logic                dclip_ff[0:E];

   logic [RW-1:0]       rem_in  [1:E][0:8];
   logic [E-1:0]        q_in    [1:E][0:8];

   logic [mi3_pkg::OUT_TDATA_W-1:0] out_data_in;
   logic [mi3_pkg::USER_W-1:0]      out_user_in;
   logic                            rsp_vld_ff;
   logic [mi3_pkg::OUT_TDATA_W-1:0] rsp_data_ff;
   logic [mi3_pkg::USER_W-1:0]      rsp_user_ff;
   logic                            skid_vld_ff;
   logic [mi3_pkg::OUT_TDATA_W-1:0] skid_data_ff;
   logic [mi3_pkg::USER_W-1:0]      skid_user_ff;

   assign pipe_en    = !skid_vld_ff;
   assign req_tready = pipe_en;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // stage 6: signs, magnitudes, determinant output
   always_comb begin
      logic [CW-1:0]        cabs;
      logic signed [DW-1:0] dsh;
      logic [DW-E:0]        dtop;
      logic                 fits;
      for (int k = 0; k < 9; k++) begin
         cabs       = c5_ff[k][CW-1] ? CW'(-c5_ff[k]) : CW'(c5_ff[k]);
         num_in[k]  = NW'(cabs) << F2;
         neg6_in[k] = c5_ff[k][CW-1] ^ det_ff[DW-1];
      end
      den6_in   = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
      dsh       = det_ff >>> F2;
      dtop      = dsh[DW-1:E-1];
      fits      = (dtop == '0) || (&dtop);
      dclip6_in = !fits;
      if (fits) begin
         dval6_in = dsh[E-1:0];
      end else if (det_ff[DW-1]) begin
         dval6_in = {1'b1, {(E-1){1'b0}}};
      end else begin
         dval6_in = {1'b0, {(E-1){1'b1}}};
      end
   end

   // divider: one quotient bit per stage, MSB first
   always_comb begin
      logic [RW-1:0] sh;
      for (int d = 1; d <= E; d++) begin
         sh = RW'(den_ff[d-1]) << (E - d);
         for (int k = 0; k < 9; k++) begin
            if (rem_ff[d-1][k] >= sh) begin
               rem_in[d][k] = rem_ff[d-1][k] - sh;
               q_in[d][k]   = q_ff[d-1][k] | (E'(1) << (E - d));
            end else begin
               rem_in[d][k] = rem_ff[d-1][k];
               q_in[d][k]   = q_ff[d-1][k];
            end
         end
      end
   end

   // sign, saturation and singular override
   always_comb begin
      logic [E-1:0]        qm;
      logic signed [E-1:0] val;
      logic                clip;
      logic                any_clip;
      any_clip = dclip_ff[E];
      for (int k = 0; k < 9; k++) begin
         qm   = q_ff[E][k];
         clip = 1'b0;
         if (ovf_ff[E][k]) begin
            clip = 1'b1;
            val  = neg_ff[E][k] ? {1'b1, {(E-1){1'b0}}} : {1'b0, {(E-1){1'b1}}};
         end else if (neg_ff[E][k]) begin
            if ({1'b0, qm} > ((E+1)'(1) << (E - 1))) begin
               clip = 1'b1;
               val  = {1'b1, {(E-1){1'b0}}};
            end else begin
               val = -$signed(qm);
            end
         end else if (qm[E-1]) begin
            clip = 1'b1;
            val  = {1'b0, {(E-1){1'b1}}};
         end else begin
            val = $signed(qm);
         end
         any_clip = any_clip | clip;
         if (sing_ff[E]) begin
            out_data_in[k*WW +: WW] = (k == 0 || k == 4 || k == 8) ?
                                      (WW'(1) << FRAC_BITS) : '0;
         end else begin
            out_data_in[k*WW +: WW] = WW'(val);
         end
      end
      out_data_in[9*WW +: WW] = sing_ff[E] ? '0 : WW'(dval_ff[E]);
      out_user_in[mi3_pkg::USER_SINGULAR]  = sing_ff[E];
      out_user_in[mi3_pkg::USER_SATURATED] = !sing_ff[E] && any_clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         dv_ff <= '0;
      end else if (pipe_en) begin
         v_ff  <= {v_ff[5:0], req_tvalid};
         dv_ff <= {dv_ff[E-1:0], v_ff[6]};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int k = 0; k < 9; k++) begin
            m_ff[k] <= $signed(req_tdata[k*WW +: E]);
         end
         for (int k = 0; k < 9; k++) begin
            p_ff[2*k]   <= m_ff[mi3_pkg::COF_IDX[k][0]] * m_ff[mi3_pkg::COF_IDX[k][1]];
            p_ff[2*k+1] <= m_ff[mi3_pkg::COF_IDX[k][2]] * m_ff[mi3_pkg::COF_IDX[k][3]];
         end
         for (int j = 0; j < 3; j++) begin
            r1_ff[j] <= m_ff[j];
            r2_ff[j] <= r1_ff[j];
         end
         for (int k = 0; k < 9; k++) begin
            c2_ff[k] <= CW'(p_ff[2*k]) - CW'(p_ff[2*k+1]);
            c3_ff[k] <= c2_ff[k];
            c4_ff[k] <= c3_ff[k];
            c5_ff[k] <= c4_ff[k];
         end
         for (int j = 0; j < 3; j++) begin
            lo_ff[j] <= r2_ff[j] * $signed({1'b0, c2_ff[mi3_pkg::DET_COF[j]][E-1:0]});
            hi_ff[j] <= r2_ff[j] * $signed(c2_ff[mi3_pkg::DET_COF[j]][CW-1:E]);
            pr_ff[j] <= (DW'(hi_ff[j]) <<< E) + DW'(lo_ff[j]);
         end
         det_ff <= pr_ff[0] + pr_ff[1] + pr_ff[2];

         for (int k = 0; k < 9; k++) begin
            num_ff[k]  <= num_in[k];
            neg6_ff[k] <= neg6_in[k];
         end
         den6_ff   <= den6_in;
         sing6_ff  <= (det_ff == '0);
         dval6_ff  <= dval6_in;
         dclip6_ff <= dclip6_in;

         for (int k = 0; k < 9; k++) begin
            rem_ff[0][k] <= RW'(num_ff[k]);
            q_ff[0][k]   <= '0;
            ovf_ff[0][k] <= RW'(num_ff[k]) >= (RW'(den6_ff) << E);
            neg_ff[0][k] <= neg6_ff[k];
         end
         den_ff[0]   <= den6_ff;
         sing_ff[0]  <= sing6_ff;
         dval_ff[0]  <= dval6_ff;
         dclip_ff[0] <= dclip6_ff;

         for (int d = 1; d <= E; d++) begin
            for (int k = 0; k < 9; k++) begin
               rem_ff[d][k] <= rem_in[d][k];
               q_ff[d][k]   <= q_in[d][k];
               ovf_ff[d][k] <= ovf_ff[d-1][k];
               neg_ff[d][k] <= neg_ff[d-1][k];
            end
            den_ff[d]   <= den_ff[d-1];
            sing_ff[d]  <= sing_ff[d-1];
            dval_ff[d]  <= dval_ff[d-1];
            dclip_ff[d] <= dclip_ff[d-1];
         end
      end
   end

   // output register with one-entry skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (rsp_vld_ff && rsp_tready && skid_vld_ff) begin
            rsp_data_ff <= skid_data_ff;
            rsp_user_ff <= skid_user_ff;
            skid_vld_ff <= 1'b0;
         end else if (pipe_en && dv_ff[E]) begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_data_ff <= out_data_in;
               rsp_user_ff <= out_user_in;
               rsp_vld_ff  <= 1'b1;
            end else begin
               skid_data_ff <= out_data_in;
               skid_user_ff <= out_user_in;
               skid_vld_ff  <= 1'b1;
            end
         end else if (rsp_vld_ff && rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid holds a transfer while output register is empty");

   a_skid_on_stall : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(rsp_vld_ff && !rsp_tready))
      else $error("skid filled without an output stall");

   a_singular_out : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[mi3_pkg::USER_SINGULAR] |->
         !rsp_tuser[mi3_pkg::USER_SATURATED] && (rsp_tdata[9*WW +: WW] == '0))
      else $error("singular result with saturation or nonzero determinant");

endmodule
